// ===== rtl/core/cafb_pkg.sv =====
// ----------------------------------------------------------------------------
// cafb_pkg
// Shared types, codes and constants of the CAN acceptance filter bank.
// ----------------------------------------------------------------------------
package cafb_pkg;

  // Field widths
  localparam int WORD_W = 32;
  localparam int BANK_W = 5;
  localparam int KIND_W = 2;
  // Scan counter width: holds any bank number and the bank count itself
  localparam int SCAN_W = BANK_W + 1;

  // Defaults
  localparam int                NUM_BANKS_DEF    = 28;
  localparam logic [BANK_W-1:0] SECOND_START_RST = 5'd28;

  // Received identifier word with bit 0 cleared
  localparam logic [WORD_W-1:0] ID_CLEAR_MASK = ~32'h0000_0001;

  // Item modes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_CHECK = 1'b1;

  // Controller selects
  localparam logic CTRL_FIRST  = 1'b0;
  localparam logic CTRL_SECOND = 1'b1;

  // Filter kinds; any other code is unsupported
  localparam logic [KIND_W-1:0] KIND_MASK32 = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LIST32 = 2'd1;

  typedef enum logic [1:0] {
    VERDICT_ACCEPT = 2'd0,
    VERDICT_REJECT = 2'd1,
    VERDICT_HALT   = 2'd2
  } verdict_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic wr_en;     // store the input word into its bank
    logic start;     // latch identifier and scan range
    logic scan_en;   // advance the scan pipeline
    logic capture;   // latch the scan result
    logic load_out;  // move the result into the output register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hit;       // evaluated bank accepted or halted
    logic scan_end;  // range exhausted without a hit
  } dp_status_t;

endpackage

// ===== rtl/core/cafb_in_if.sv =====
// ----------------------------------------------------------------------------
// cafb_in_if
// Input channel: bank write or identifier check words.
// ----------------------------------------------------------------------------
interface cafb_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [4:0]  bank_index;
  logic        filter_enable;
  logic [1:0]  filter_kind;
  logic [31:0] first_word;
  logic [31:0] second_word;
  logic [31:0] frame_id_word;
  logic        controller_select;

  modport source (
    output valid, mode, bank_index, filter_enable, filter_kind, first_word,
           second_word, frame_id_word, controller_select,
    input  ready
  );
  modport sink (
    input  valid, mode, bank_index, filter_enable, filter_kind, first_word,
           second_word, frame_id_word, controller_select,
    output ready
  );
endinterface

// ===== rtl/core/cafb_out_if.sv =====
// ----------------------------------------------------------------------------
// cafb_out_if
// Result channel: verdict and bank of one identifier check.
// ----------------------------------------------------------------------------
interface cafb_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;
  logic [4:0] hit_bank;

  modport source (
    output valid, verdict, hit_bank,
    input  ready
  );
  modport sink (
    input  valid, verdict, hit_bank,
    output ready
  );
endinterface

// ===== rtl/core/cafb_cfg_if.sv =====
// ----------------------------------------------------------------------------
// cafb_cfg_if
// Configuration write channel: start bank of the second controller.
// ----------------------------------------------------------------------------
interface cafb_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] second_start_bank;

  modport source (
    output valid, second_start_bank,
    input  ready
  );
  modport sink (
    input  valid, second_start_bank,
    output ready
  );
endinterface

// ===== rtl/core/cafb_ctrl.sv =====
// ----------------------------------------------------------------------------
// cafb_ctrl
// Sequencer of the filter bank: takes words, runs the bank scan and hands
// the result to the output register.
// ----------------------------------------------------------------------------
module cafb_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_mode,
  output logic                  in_ready,
  input  logic                  out_ready,
  output logic                  out_valid,
  input  cafb_pkg::dp_status_t  status,
  output cafb_pkg::dp_cmd_t     cmd
);
  import cafb_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // State and output valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_mode == MODE_WRITE) begin
            cmd.wr_en = 1'b1;
          end else begin
            cmd.start = 1'b1;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_en = 1'b1;
        if (status.hit || status.scan_end) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_DONE;
        end
      end
      ST_DONE: begin
        // Hold the result until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/core/cafb_datapath.sv =====
// ----------------------------------------------------------------------------
// cafb_datapath
// Filter storage, start bank register, scan counter and match logic.
// ----------------------------------------------------------------------------
module cafb_datapath #(
  parameter int NUM_BANKS = cafb_pkg::NUM_BANKS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cafb_pkg::dp_cmd_t           cmd,
  output cafb_pkg::dp_status_t        status,
  // Configuration
  input  logic                        cfg_we,
  input  logic [cafb_pkg::BANK_W-1:0] cfg_second_start,
  // Input word payload
  input  logic [cafb_pkg::BANK_W-1:0] bank_index,
  input  logic                        filter_enable,
  input  logic [cafb_pkg::KIND_W-1:0] filter_kind,
  input  logic [cafb_pkg::WORD_W-1:0] first_word,
  input  logic [cafb_pkg::WORD_W-1:0] second_word,
  input  logic [cafb_pkg::WORD_W-1:0] frame_id_word,
  input  logic                        controller_select,
  // Output payload
  output logic [1:0]                  out_verdict,
  output logic [cafb_pkg::BANK_W-1:0] out_hit_bank
);
  import cafb_pkg::*;

  localparam int                IDX_W   = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
  localparam logic [SCAN_W-1:0] BANKS_C = SCAN_W'(NUM_BANKS);

  // Start bank register
  logic [BANK_W-1:0] second_start_r;

  // Per-bank control flops and word memory
  logic                active_r [NUM_BANKS];
  logic [KIND_W-1:0]   kind_r   [NUM_BANKS];
  logic [2*WORD_W-1:0] word_mem [NUM_BANKS];
  logic [2*WORD_W-1:0] rd_words_r;

  // Scan state
  logic [SCAN_W-1:0] cur_r, hi_r, pbank_r;
  logic              pend_r;
  logic [WORD_W-1:0] id_r;

  // Result and output registers
  verdict_t          res_verdict_r, out_verdict_r;
  logic [BANK_W-1:0] res_bank_r, out_bank_r;

  logic [SCAN_W-1:0] ss_ext, hi_first, lo_start, hi_start;
  logic              wr_hit, issue;
  logic [IDX_W-1:0]  wr_idx, rd_idx, p_idx;
  logic [WORD_W-1:0] w0, w1;
  logic [KIND_W-1:0] p_kind;
  logic              p_unsup, p_match;

  // Write decode
  assign wr_hit = cmd.wr_en && ({1'b0, bank_index} < BANKS_C);
  assign wr_idx = bank_index[IDX_W-1:0];

  // Scan range of the selected controller
  assign ss_ext   = {1'b0, second_start_r};
  assign hi_first = (ss_ext < BANKS_C) ? ss_ext : BANKS_C;
  assign lo_start = (controller_select == CTRL_SECOND) ? ss_ext : '0;
  assign hi_start = (controller_select == CTRL_SECOND) ? BANKS_C : hi_first;

  // Read one bank per cycle while the range lasts
  assign issue  = cmd.scan_en && (cur_r < hi_r);
  assign rd_idx = cur_r[IDX_W-1:0];

  // Evaluate the bank read in the previous cycle
  assign p_idx   = pbank_r[IDX_W-1:0];
  assign p_kind  = kind_r[p_idx];
  assign w0      = rd_words_r[WORD_W-1:0];
  assign w1      = rd_words_r[2*WORD_W-1:WORD_W];
  assign p_unsup = (p_kind != KIND_MASK32) && (p_kind != KIND_LIST32);
  assign p_match = (p_kind == KIND_LIST32) ? ((w0 == id_r) || (w1 == id_r))
                                           : (((w0 ^ id_r) & w1) == '0);

  assign status.hit      = pend_r && active_r[p_idx] && (p_unsup || p_match);
  assign status.scan_end = !pend_r && !(cur_r < hi_r);

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      second_start_r <= SECOND_START_RST;
    end else if (cfg_we) begin
      second_start_r <= cfg_second_start;
    end
  end

  // Bank enable and kind flops
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_BANKS; i++) begin
        active_r[i] <= 1'b0;
        kind_r[i]   <= KIND_MASK32;
      end
    end else if (wr_hit) begin
      active_r[wr_idx] <= filter_enable;
      kind_r[wr_idx]   <= filter_kind;
    end
  end

  // Word memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_hit) begin
      word_mem[wr_idx] <= {second_word, first_word};
    end
    if (issue) begin
      rd_words_r <= word_mem[rd_idx];
    end
  end

  // Scan control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= 1'b0;
      cur_r   <= '0;
      hi_r    <= '0;
      pbank_r <= '0;
    end else if (cmd.start) begin
      pend_r <= 1'b0;
      cur_r  <= lo_start;
      hi_r   <= hi_start;
    end else if (cmd.scan_en) begin
      pend_r <= issue;
      if (issue) begin
        pbank_r <= cur_r;
        cur_r   <= cur_r + SCAN_W'(1);
      end
    end
  end

  // Identifier with bit 0 cleared
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      id_r <= frame_id_word & ID_CLEAR_MASK;
    end
  end

  // Result capture and output register
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      if (status.hit) begin
        res_verdict_r <= p_unsup ? VERDICT_HALT : VERDICT_ACCEPT;
        res_bank_r    <= pbank_r[BANK_W-1:0];
      end else begin
        res_verdict_r <= VERDICT_REJECT;
        res_bank_r    <= '0;
      end
    end
    if (cmd.load_out) begin
      out_verdict_r <= res_verdict_r;
      out_bank_r    <= res_bank_r;
    end
  end

  assign out_verdict  = out_verdict_r;
  assign out_hit_bank = out_bank_r;

endmodule

// ===== rtl/core/can_acceptance_filter_bank.sv =====
// ----------------------------------------------------------------------------
// can_acceptance_filter_bank
// Bank of 32-bit mask and list CAN identifier filters, scanned one bank per
// cycle in ascending order for the selected controller's range.
//
//   Channel  Dir  Word contents
//   in_ch    in   write: bank_index, enable, kind, two words / check: id, ctrl
//   out_ch   out  verdict, hit_bank (one word per check, none per write)
//   cfg_ch   in   second_start_bank (always ready)
//
// A write word is stored in its bank when taken. A check word scans the banks up to
// the hit or the end of the range, with one read of the filter word memory per bank;
// the input stays closed until its result is handed to the output register.
// Reset clears all bank enables and kinds and sets the start bank to 28.
// A finished result waits in the output register; a later check stalls in
// its last step only while that register is still full.
// ----------------------------------------------------------------------------
module can_acceptance_filter_bank #(
  parameter int NUM_BANKS = cafb_pkg::NUM_BANKS_DEF
) (
  input logic         clk,
  input logic         rst_n,
  cafb_in_if.sink     in_ch,
  cafb_out_if.source  out_ch,
  cafb_cfg_if.sink    cfg_ch
);
  import cafb_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       cfg_we;

  // Configuration is always taken
  assign cfg_ch.ready = 1'b1;
  assign cfg_we       = cfg_ch.valid && cfg_ch.ready;

  cafb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_mode   (in_ch.mode),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .status    (status),
    .cmd       (cmd)
  );

  cafb_datapath #(
    .NUM_BANKS (NUM_BANKS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .cfg_we            (cfg_we),
    .cfg_second_start  (cfg_ch.second_start_bank),
    .bank_index        (in_ch.bank_index),
    .filter_enable     (in_ch.filter_enable),
    .filter_kind       (in_ch.filter_kind),
    .first_word        (in_ch.first_word),
    .second_word       (in_ch.second_word),
    .frame_id_word     (in_ch.frame_id_word),
    .controller_select (in_ch.controller_select),
    .out_verdict       (out_ch.verdict),
    .out_hit_bank      (out_ch.hit_bank)
  );

  // A check word keeps the input closed for the next cycle
  a_check_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && (in_ch.mode == MODE_CHECK)) |=> !in_ch.ready)
    else $error("input taken right after a check word");

  // A rejected frame reports bank 0
  a_reject_bank: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.verdict == VERDICT_REJECT)) |-> (out_ch.hit_bank == '0))
    else $error("rejected frame with nonzero bank");

  // An accepting or halting bank lies inside the bank array
  a_hit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.verdict != VERDICT_REJECT))
      |-> ({1'b0, out_ch.hit_bank} < SCAN_W'(NUM_BANKS)))
    else $error("hit bank beyond bank count");

  // After a scan completes, the sequencer has left the scan and keeps the input closed
  a_capture_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> !in_ch.ready && !cmd.scan_en)
    else $error("sequencer left scan without holding the result");

endmodule

// ===== sim/can_acceptance_filter_bank_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// can_acceptance_filter_bank_tb
// Drives bank writes and identifier checks into the filter bank and checks
// every verdict against a cycle-free prediction of the bank scan. Runs under
// several second-controller start banks, with random idling on both sides and
// one long result hold-off that backs the block up.
// ----------------------------------------------------------------------------
module can_acceptance_filter_bank_tb;
  import cafb_pkg::*;

  localparam int NBANKS        = NUM_BANKS_DEF;
  localparam int PHASE_WORDS   = 160;
  localparam int SETTLE_CYCLES = 12;
  localparam int STALL_LIMIT   = 3000;
  localparam int HOLD_CYCLES   = 400;
  localparam int HOLD_AFTER    = 150;

  // Filter kind codes that the block does not support
  localparam logic [KIND_W-1:0] KIND_UNSUP_A = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UNSUP_B = 2'd3;

  // One input word, write or check
  typedef struct {
    logic        mode;
    logic [4:0]  bank_index;
    logic        filter_enable;
    logic [1:0]  filter_kind;
    logic [31:0] first_word;
    logic [31:0] second_word;
    logic [31:0] frame_id_word;
    logic        controller_select;
  } filter_word_t;

  // One expected result word
  typedef struct {
    verdict_t   verdict;
    logic [4:0] hit_bank;
  } verdict_word_t;

  // Holds a copy of the filter banks and the verdicts still owed by the block
  class filter_scoreboard;
    bit            active[NBANKS];
    logic [1:0]    kind[NBANKS];
    logic [31:0]   first_w[NBANKS];
    logic [31:0]   second_w[NBANKS];
    logic [4:0]    second_start;
    verdict_word_t verdict_q[$];
    int errors, writes, checked, accepts, rejects, halts, start_writes;

    function new();
      second_start = SECOND_START_RST;
      for (int b = 0; b < NBANKS; b++) begin
        active[b]   = 1'b0;
        kind[b]     = KIND_MASK32;
        first_w[b]  = '0;
        second_w[b] = '0;
      end
    endfunction

    function void write_start(logic [4:0] v);
      second_start = v;
      start_writes++;
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction

    // Scan the selected range; first active match accepts, unsupported halts
    function verdict_word_t predict_verdict(logic [31:0] id_word, logic sel);
      verdict_word_t r;
      logic [31:0] id;
      int lo, hi;
      bit hit;
      id = id_word & ID_CLEAR_MASK;
      if (sel == CTRL_FIRST) begin
        lo = 0;
        hi = (second_start < NBANKS) ? second_start : NBANKS;
      end else begin
        lo = second_start;
        hi = NBANKS;
      end
      r.verdict  = VERDICT_REJECT;
      r.hit_bank = '0;
      for (int b = lo; b < hi; b++) begin
        if (!active[b]) continue;
        if (kind[b] != KIND_MASK32 && kind[b] != KIND_LIST32) begin
          r.verdict  = VERDICT_HALT;
          r.hit_bank = 5'(b);
          break;
        end
        if (kind[b] == KIND_LIST32)
          hit = (first_w[b] == id) || (second_w[b] == id);
        else
          hit = ((first_w[b] ^ id) & second_w[b]) == 32'h0;
        if (hit) begin
          r.verdict  = VERDICT_ACCEPT;
          r.hit_bank = 5'(b);
          break;
        end
      end
      return r;
    endfunction

    // Note an accepted input word: store a bank or queue a verdict
    function void note_input(filter_word_t w);
      if (w.mode == MODE_WRITE) begin
        writes++;
        if (w.bank_index < NBANKS) begin
          active[w.bank_index]   = w.filter_enable;
          kind[w.bank_index]     = w.filter_kind;
          first_w[w.bank_index]  = w.first_word;
          second_w[w.bank_index] = w.second_word;
        end
      end else begin
        verdict_q.push_back(predict_verdict(w.frame_id_word, w.controller_select));
      end
    endfunction

    // Compare one result word with the oldest expected verdict
    function void check_result(logic [1:0] verdict, logic [4:0] hit_bank);
      verdict_word_t e;
      if (verdict_q.size() == 0) begin
        $error("unexpected result word: verdict %0d, hit_bank %0d", verdict, hit_bank);
        errors++;
        return;
      end
      e = verdict_q.pop_front();
      checked++;
      case (e.verdict)
        VERDICT_ACCEPT: accepts++;
        VERDICT_REJECT: rejects++;
        default:        halts++;
      endcase
      if (verdict !== e.verdict) begin
        $error("verdict mismatch: expected %0d, actual %0d", e.verdict, verdict);
        errors++;
      end
      if (hit_bank !== e.hit_bank) begin
        $error("hit_bank mismatch: expected %0d, actual %0d", e.hit_bank, hit_bank);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   quiet_run;
  bit   reset_done;
  int   stall_cycles;

  filter_scoreboard sb = new();

  cafb_in_if  in_if();
  cafb_out_if out_if();
  cafb_cfg_if cfg_if();

  can_acceptance_filter_bank uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watch all three channels; count cycles with no handshake
  always @(posedge clk) begin
    filter_word_t w;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        w.mode              = in_if.mode;
        w.bank_index        = in_if.bank_index;
        w.filter_enable     = in_if.filter_enable;
        w.filter_kind       = in_if.filter_kind;
        w.first_word        = in_if.first_word;
        w.second_word       = in_if.second_word;
        w.frame_id_word     = in_if.frame_id_word;
        w.controller_select = in_if.controller_select;
        sb.note_input(w);
      end
      if (out_if.valid && out_if.ready)
        sb.check_result(out_if.verdict, out_if.hit_bank);
      if (cfg_if.valid && cfg_if.ready)
        sb.write_start(cfg_if.second_start_bank);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
    end
  end

  // Give up when nothing moves for too long
  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  // Result side: random stall bursts and one long hold-off
  initial begin
    int  stall_left;
    bit  held_off;
    stall_left = 0;
    held_off   = 1'b0;
    out_if.ready <= 1'b0;
    wait (reset_done);
    forever begin
      @(posedge clk);
      if (!held_off && sb.checked >= HOLD_AFTER) begin
        held_off = 1'b1;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (!quiet_run && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 7) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Offer one word, with an optional idle burst first; valid stays high after
  task automatic send_word(input filter_word_t w);
    if (!quiet_run && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_if.valid             <= 1'b1;
    in_if.mode              <= w.mode;
    in_if.bank_index        <= w.bank_index;
    in_if.filter_enable     <= w.filter_enable;
    in_if.filter_kind       <= w.filter_kind;
    in_if.first_word        <= w.first_word;
    in_if.second_word       <= w.second_word;
    in_if.frame_id_word     <= w.frame_id_word;
    in_if.controller_select <= w.controller_select;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  // Drop valid and wait until every owed verdict is back and the block settles
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_second_start(input logic [4:0] v);
    cfg_if.valid             <= 1'b1;
    cfg_if.second_start_bank <= v;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic filter_word_t make_write(int idx, bit en, int kind_code,
                                              logic [31:0] w0, logic [31:0] w1);
    filter_word_t w;
    w.mode              = MODE_WRITE;
    w.bank_index        = 5'(idx);
    w.filter_enable     = en;
    w.filter_kind       = 2'(kind_code);
    w.first_word        = w0;
    w.second_word       = w1;
    w.frame_id_word     = $urandom;
    w.controller_select = 1'($urandom_range(0, 1));
    return w;
  endfunction

  function automatic filter_word_t make_check(logic [31:0] id, logic sel);
    filter_word_t w;
    w.mode              = MODE_CHECK;
    w.bank_index        = 5'($urandom_range(0, 31));
    w.filter_enable     = 1'($urandom_range(0, 1));
    w.filter_kind       = 2'($urandom_range(0, 3));
    w.first_word        = $urandom;
    w.second_word       = $urandom;
    w.frame_id_word     = id;
    w.controller_select = sel;
    return w;
  endfunction

  // Random word: mostly supported filters, checks mostly aimed at a live bank
  function automatic filter_word_t make_random_word();
    filter_word_t w;
    int lo, hi, b, r;
    w = make_check($urandom, 1'($urandom_range(0, 1)));
    if ($urandom_range(0, 99) < 45) begin
      w.mode = MODE_WRITE;
      if ($urandom_range(0, 9) == 0)
        w.bank_index = 5'($urandom_range(NBANKS, 31));
      else
        w.bank_index = 5'($urandom_range(0, NBANKS - 1));
      w.filter_enable = ($urandom_range(0, 9) < 7);
      r = $urandom_range(0, 49);
      if (r == 0)      w.filter_kind = KIND_UNSUP_A;
      else if (r == 1) w.filter_kind = KIND_UNSUP_B;
      else             w.filter_kind = ($urandom_range(0, 1) != 0) ? KIND_LIST32 : KIND_MASK32;
      r = $urandom_range(0, 9);
      if (r == 0)      w.second_word = 32'h0;
      else if (r < 5)  w.second_word = $urandom & $urandom & $urandom;
      else             w.second_word = $urandom;
    end else if ($urandom_range(0, 9) < 7) begin
      if (w.controller_select == CTRL_FIRST) begin
        lo = 0;
        hi = (sb.second_start < NBANKS) ? int'(sb.second_start) : NBANKS;
      end else begin
        lo = sb.second_start;
        hi = NBANKS;
      end
      if (hi > lo) begin
        b = $urandom_range(lo, hi - 1);
        if (sb.active[b] && sb.kind[b] == KIND_LIST32)
          w.frame_id_word = (($urandom_range(0, 1) != 0) ? sb.first_w[b] : sb.second_w[b])
                            ^ 32'($urandom_range(0, 1));
        else if (sb.active[b] && sb.kind[b] == KIND_MASK32)
          w.frame_id_word = (sb.first_w[b] & sb.second_w[b]) | ($urandom & ~sb.second_w[b]);
      end
    end
    return w;
  endfunction

  // Main sequence
  initial begin
    logic [4:0] starts[5];
    rst_n                   <= 1'b0;
    in_if.valid             <= 1'b0;
    in_if.mode              <= MODE_WRITE;
    in_if.bank_index        <= '0;
    in_if.filter_enable     <= 1'b0;
    in_if.filter_kind       <= KIND_MASK32;
    in_if.first_word        <= '0;
    in_if.second_word       <= '0;
    in_if.frame_id_word     <= '0;
    in_if.controller_select <= CTRL_FIRST;
    cfg_if.valid            <= 1'b0;
    cfg_if.second_start_bank <= '0;
    stall_cycles            <= 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    reset_done = 1'b1;

    // Directed: empty banks, list and mask hits, bit 0 clearing, halts, bad index
    send_word(make_check(32'hFFFF_FFFF, CTRL_FIRST));
    send_word(make_write(0, 1, KIND_MASK32, 32'h0, 32'h0));
    send_word(make_check(32'hFFFF_FFFF, CTRL_FIRST));
    send_word(make_write(27, 1, KIND_LIST32, 32'hFFFF_FFFE, 32'h1234_5678));
    send_word(make_write(0, 0, KIND_MASK32, 32'h0, 32'h0));
    send_word(make_check(32'hFFFF_FFFF, CTRL_FIRST));
    send_word(make_check(32'h1234_5679, CTRL_FIRST));
    send_word(make_check(32'h1234_5678, CTRL_SECOND));
    send_word(make_write(28, 1, KIND_MASK32, 32'h0, 32'h0));
    send_word(make_write(31, 1, KIND_MASK32, 32'h0, 32'h0));
    send_word(make_check(32'h0000_0000, CTRL_FIRST));
    send_word(make_write(5, 1, KIND_UNSUP_A, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_word(make_check(32'h1234_5678, CTRL_FIRST));
    send_word(make_write(6, 1, KIND_UNSUP_B, 32'h0, 32'h0));
    send_word(make_write(5, 0, KIND_UNSUP_A, 32'h0, 32'h0));
    send_word(make_check(32'h0000_0000, CTRL_FIRST));
    send_word(make_write(6, 0, KIND_UNSUP_B, 32'h0, 32'h0));
    send_word(make_write(10, 1, KIND_MASK32, 32'hA5A5_0000, 32'hFFFF_0000));
    send_word(make_check(32'hA5A5_1235, CTRL_FIRST));
    send_word(make_check(32'h5A5A_0000, CTRL_FIRST));
    send_word(make_write(11, 1, KIND_LIST32, 32'h0000_0001, 32'h0000_0003));
    send_word(make_check(32'h0000_0001, CTRL_FIRST));
    send_word(make_check(32'h0000_0003, CTRL_FIRST));
    wait_idle();

    // Random phases under different start banks; last phase runs without idling
    starts = '{5'd0, 5'd31, 5'd14, 5'd28, 5'($urandom_range(1, 27))};
    for (int p = 0; p < 5; p++) begin
      write_second_start(starts[p]);
      quiet_run = (p == 4);
      for (int i = 0; i < PHASE_WORDS; i++)
        send_word(make_random_word());
      wait_idle();
    end

    $display("covered %0d input words, %0d verdicts (%0d accept, %0d reject, %0d halt)",
             sb.writes + sb.checked, sb.checked, sb.accepts, sb.rejects, sb.halts);
    $display("under %0d start bank settings, with one long result hold-off",
             sb.start_writes);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/cafb_pkg.sv
rtl/core/cafb_in_if.sv
rtl/core/cafb_out_if.sv
rtl/core/cafb_cfg_if.sv
rtl/core/cafb_ctrl.sv
rtl/core/cafb_datapath.sv
rtl/core/can_acceptance_filter_bank.sv
sim/can_acceptance_filter_bank_tb.sv
